>>> sv/radix_digit_converter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radix digit converter
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_MACROS_SVH

// same-cycle implication
`define RDC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdc: same-cycle check failed");

// next-cycle implication
`define RDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdc: next-cycle check failed");

`endif

>>> sv/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Widths, status codes, control bundles and the digit-to-ASCII map shared
// by the radix digit converter modules.
// ----------------------------------------------------------------------------
package rdc_pkg;

   // field widths
   localparam int VALUE_WIDTH = 32;
   localparam int MAG_WIDTH   = VALUE_WIDTH - 1;
   localparam int BASE_WIDTH  = 5;
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH  = 7;
   localparam int STAT_WIDTH  = 2;

   // digit buffer
   localparam int MAX_DIGITS = 31;
   localparam int ADDR_WIDTH = $clog2(MAX_DIGITS);
   localparam int CNT_WIDTH  = $clog2(MAX_DIGITS + 1);

   // divider: quotient bits resolved per cycle
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_CYCLES    = (MAG_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int QUO_WIDTH     = DIV_CYCLES * DIV_STEP_BITS;
   localparam int STEP_WIDTH    = $clog2(DIV_CYCLES);

   // stream word widths, padded to bytes
   localparam int REQ_TDATA_WIDTH = ((VALUE_WIDTH + BASE_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH = ((CHAR_WIDTH + 7) / 8) * 8;

   // legal radix range
   localparam logic [BASE_WIDTH-1:0] BASE_MIN = BASE_WIDTH'(2);
   localparam logic [BASE_WIDTH-1:0] BASE_MAX = BASE_WIDTH'(16);

   // result status codes
   localparam logic [STAT_WIDTH-1:0] ST_OK           = 2'd0;
   localparam logic [STAT_WIDTH-1:0] ST_NOT_POSITIVE = 2'd1;
   localparam logic [STAT_WIDTH-1:0] ST_BAD_BASE     = 2'd2;

   // ASCII anchors
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_A    = 7'h41;

   // divider start request
   typedef struct packed {
      logic                  start;
      logic [MAG_WIDTH-1:0]  dividend;
      logic [BASE_WIDTH-1:0] base;
   } div_req_type;

   // divider result
   typedef struct packed {
      logic                   done;
      logic [MAG_WIDTH-1:0]   quotient;
      logic [DIGIT_WIDTH-1:0] remainder;
   } div_rsp_type;

   // digit buffer write port
   typedef struct packed {
      logic                   en;
      logic [ADDR_WIDTH-1:0]  addr;
      logic [DIGIT_WIDTH-1:0] data;
   } store_wr_type;

   // digit value to ASCII '0'..'9', 'A'..'F'
   function automatic logic [CHAR_WIDTH-1:0] to_ascii(input logic [DIGIT_WIDTH-1:0] d);
      logic [DIGIT_WIDTH-1:0] hi;
      hi = d - DIGIT_WIDTH'(10);
      if (d < DIGIT_WIDTH'(10)) begin
         return CHAR_ZERO + CHAR_WIDTH'(d);
      end else begin
         return CHAR_A + CHAR_WIDTH'(hi);
      end
   endfunction

endpackage

>>> sv/radix_digit_converter.sv
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts a signed integer to ASCII digits in a radix from 2 to 16, most
// significant digit first, tlast on the final digit.
// ----------------------------------------------------------------------------
// One word in, one conversion at a time; req_tready stays low until the last
// result word of the conversion has been taken from the output register.
// A positive value is divided by the base again and again in the shared
// divider, which resolves 4 quotient bits a cycle, until the quotient is
// zero or the buffer is full; each remainder goes into the digit buffer,
// and each buffered digit is then read back and loaded into the output
// register, which waits while the receiver holds off. A base outside 2..16
// or a value that is zero or negative gives a single status word on the next
// cycle. tuser carries the status: 0 digit, 1 value not positive, 2 bad base.
`include "radix_digit_converter_macros.svh"

module radix_digit_converter
   import rdc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // req_tdata: [31:0] value, [36:32] target_base, [39:37] zero
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // rsp_tdata: [6:0] digit_char, [7] zero
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // rsp_tuser: [1:0] status
   output logic [STAT_WIDTH-1:0]      rsp_tuser,
   output logic                       rsp_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_LOAD = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [ADDR_WIDTH-1:0]  rd_idx_ff, rd_idx_in;
   logic [BASE_WIDTH-1:0]  base_ff, base_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_load;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic [STAT_WIDTH-1:0]  rsp_stat_ff, rsp_stat_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0] in_value;
   logic [BASE_WIDTH-1:0]  in_base;
   logic                   bad_base;
   logic                   not_positive;
   logic                   req_take;
   logic                   rsp_take;

   div_req_type            div_req;
   div_rsp_type            div_rsp;
   store_wr_type           st_wr;
   logic                   st_rd_en;
   logic [DIGIT_WIDTH-1:0] st_rd_data;

   rdc_div_unit u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   rdc_digit_store u_store (
      .clock   (clock),
      .wr      (st_wr),
      .rd_en   (st_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (st_rd_data)
   );

   // input word decode
   assign in_value     = req_tdata[VALUE_WIDTH-1:0];
   assign in_base      = req_tdata[VALUE_WIDTH +: BASE_WIDTH];
   assign bad_base     = (in_base < BASE_MIN) || (in_base > BASE_MAX);
   assign not_positive = in_value[VALUE_WIDTH-1] || (in_value[MAG_WIDTH-1:0] == '0);

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = rsp_valid_ff && rsp_tready;

   // sequencer
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      rd_idx_in        = rd_idx_ff;
      base_in          = base_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_take;
      rsp_load         = 1'b0;
      rsp_char_in      = rsp_char_ff;
      rsp_stat_in      = rsp_stat_ff;
      rsp_last_in      = rsp_last_ff;
      div_req.start    = 1'b0;
      div_req.dividend = in_value[MAG_WIDTH-1:0];
      div_req.base     = in_base;
      st_wr.en         = 1'b0;
      st_wr.addr       = count_ff[ADDR_WIDTH-1:0];
      st_wr.data       = div_rsp.remainder;
      st_rd_en         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (bad_base || not_positive) begin
                  rsp_valid_in = 1'b1;
                  rsp_load     = 1'b1;
                  rsp_char_in  = '0;
                  rsp_stat_in  = bad_base ? ST_BAD_BASE : ST_NOT_POSITIVE;
                  rsp_last_in  = 1'b1;
               end else begin
                  div_req.start = 1'b1;
                  base_in       = in_base;
                  count_in      = '0;
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               st_wr.en = 1'b1;
               count_in = count_ff + CNT_WIDTH'(1);
               if ((div_rsp.quotient == '0) || (count_ff == CNT_WIDTH'(MAX_DIGITS - 1))) begin
                  rd_idx_in = count_ff[ADDR_WIDTH-1:0];
                  state_in  = S_READ;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = div_rsp.quotient;
                  div_req.base     = base_ff;
               end
            end
         end
         S_READ: begin
            st_rd_en = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in = 1'b1;
               rsp_load     = 1'b1;
               rsp_char_in  = to_ascii(st_rd_data);
               rsp_stat_in  = ST_OK;
               rsp_last_in  = (rd_idx_ff == '0);
               if (rd_idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff - ADDR_WIDTH'(1);
                  state_in  = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      base_ff   <= base_in;
      if (rsp_load) begin
         rsp_char_ff <= rsp_char_in;
         rsp_stat_ff <= rsp_stat_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_WIDTH'(rsp_char_ff);
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `RDC_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)
   `RDC_ASSERT_IMPL(a_status_last, clock, reset, rsp_tvalid && (rsp_tuser != ST_OK), rsp_tlast)
   `RDC_ASSERT_IMPL(a_done_in_div, clock, reset, div_rsp.done, state_ff == S_DIV)
   `RDC_ASSERT_IMPL(a_digit_char, clock, reset, rsp_tvalid && (rsp_tuser == ST_OK), ((rsp_tdata[6:0] >= 7'h30) && (rsp_tdata[6:0] <= 7'h39)) || ((rsp_tdata[6:0] >= 7'h41) && (rsp_tdata[6:0] <= 7'h46)))

endmodule

>>> sv/rdc_div_unit.sv
// ----------------------------------------------------------------------------
// rdc_div_unit
// Iterative restoring divider: magnitude by radix, several quotient bits
// per cycle, giving quotient and remainder and flagging done when ready.
// ----------------------------------------------------------------------------
module rdc_div_unit
   import rdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(DIV_CYCLES - 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_WIDTH-1:0]  step_ff;
   logic [QUO_WIDTH-1:0]   quo_ff;
   logic [DIGIT_WIDTH-1:0] rem_ff;
   logic [BASE_WIDTH-1:0]  base_ff;
   logic [QUO_WIDTH-1:0]   quo_in;
   logic [DIGIT_WIDTH-1:0] rem_in;

   // one cycle of shift-compare-subtract steps
   always_comb begin
      logic [DIGIT_WIDTH:0] trial;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int j = 0; j < DIV_STEP_BITS; j++) begin
         trial  = {rem_in, quo_in[QUO_WIDTH-1]};
         quo_in = {quo_in[QUO_WIDTH-2:0], 1'b0};
         if (trial >= (DIGIT_WIDTH + 1)'(base_ff)) begin
            trial     = trial - (DIGIT_WIDTH + 1)'(base_ff);
            quo_in[0] = 1'b1;
         end
         rem_in = trial[DIGIT_WIDTH-1:0];
      end
   end

   // busy / done flags
   always_comb begin
      done_in = busy_ff && (step_ff == STEP_LAST);
      busy_in = busy_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
      end else if (done_in) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff  <= QUO_WIDTH'(div_req.dividend);
         rem_ff  <= '0;
         step_ff <= '0;
         base_ff <= div_req.base;
      end else if (busy_ff) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + STEP_WIDTH'(1);
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff[MAG_WIDTH-1:0];
   assign div_rsp.remainder = rem_ff;

endmodule

>>> sv/rdc_digit_store.sv
// ----------------------------------------------------------------------------
// rdc_digit_store
// Remainder buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rdc_digit_store
   import rdc_pkg::*;
(
   input  logic                   clock,
   input  store_wr_type           wr,
   input  logic                   rd_en,
   input  logic [ADDR_WIDTH-1:0]  rd_addr,
   output logic [DIGIT_WIDTH-1:0] rd_data
);

   logic [DIGIT_WIDTH-1:0] mem [MAX_DIGITS];
   logic [DIGIT_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> verif/tb_radix_digit_converter.sv
// ----------------------------------------------------------------------------
// tb_radix_digit_converter
// Self-checking bench for the radix digit converter. Each request word is
// predicted locally (status word or digit string, most significant first)
// and every result word is compared field by field against the oldest
// prediction. Covers the status cases, digit extremes, random traffic with
// random idling on both channels, a long receiver hold-off and a stretch
// with no idling at all.
// ----------------------------------------------------------------------------
module tb_radix_digit_converter
   import rdc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 400;
   localparam int HOLD_CYCLES   = 500;

   // one result word as predicted
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] digit_char;
      logic [STAT_WIDTH-1:0] status;
      logic                  last;
   } digit_word_type;

   logic                       clock;
   logic                       reset;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic [STAT_WIDTH-1:0]      rsp_tuser;
   logic                       rsp_tlast;
   logic                       rsp_tvalid;
   logic                       rsp_tready;

   digit_word_type expected_digits[$];
   int             mismatch_count = 0;
   int             cycle_count    = 0;
   int             hold_left      = 0;
   bit             req_idle_en    = 1'b0;
   bit             rsp_idle_en    = 1'b0;

   radix_digit_converter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // no gap half the time, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 15);
      if (r < 8) return 0;
      if (r < 14) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // expected result words for one conversion
   function automatic void predict_conversion(input logic [VALUE_WIDTH-1:0] value,
                                              input logic [BASE_WIDTH-1:0]  radix);
      logic [MAG_WIDTH-1:0]   quotient;
      logic [DIGIT_WIDTH-1:0] digits[MAX_DIGITS];
      logic [DIGIT_WIDTH-1:0] d;
      digit_word_type         w;
      int                     count;
      // base check wins over the value check
      if (radix < BASE_MIN || radix > BASE_MAX) begin
         w = '{digit_char: '0, status: ST_BAD_BASE, last: 1'b1};
         expected_digits.push_back(w);
         return;
      end
      if (value[VALUE_WIDTH-1] || value == '0) begin
         w = '{digit_char: '0, status: ST_NOT_POSITIVE, last: 1'b1};
         expected_digits.push_back(w);
         return;
      end
      // remainders come out least significant first
      quotient = value[MAG_WIDTH-1:0];
      count    = 0;
      while (quotient != '0 && count < MAX_DIGITS) begin
         digits[count] = DIGIT_WIDTH'(quotient % MAG_WIDTH'(radix));
         quotient      = quotient / MAG_WIDTH'(radix);
         count++;
      end
      for (int i = count - 1; i >= 0; i--) begin
         d = digits[i];
         w.digit_char = (d < DIGIT_WIDTH'(10)) ? CHAR_ZERO + CHAR_WIDTH'(d)
                                               : CHAR_A + CHAR_WIDTH'(d) - CHAR_WIDTH'(10);
         w.status     = ST_OK;
         w.last       = (i == 0);
         expected_digits.push_back(w);
      end
   endfunction

   // offer one request word, hold it until accepted
   task automatic send_conversion(input logic [VALUE_WIDTH-1:0] value,
                                  input logic [BASE_WIDTH-1:0]  radix);
      int gap;
      gap = req_idle_en ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = REQ_TDATA_WIDTH'({radix, value});
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_conversion(value, radix);
   endtask

   // stop offering and wait for every outstanding result word
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed conversions, some bad bases, zeros and negatives
   task automatic send_random_item();
      int                    kind;
      int                    nbits;
      logic [VALUE_WIDTH-1:0] v;
      logic [BASE_WIDTH-1:0]  b;
      kind = $urandom_range(0, 19);
      b    = BASE_WIDTH'($urandom_range(2, 16));
      v    = VALUE_WIDTH'($urandom);
      if (kind == 0) begin
         b = $urandom_range(0, 1) ? BASE_WIDTH'($urandom_range(0, 1))
                                  : BASE_WIDTH'($urandom_range(17, 31));
      end else if (kind == 1) begin
         v = '0;
      end else if (kind == 2) begin
         v[VALUE_WIDTH-1] = 1'b1;
      end else begin
         nbits = $urandom_range(1, MAG_WIDTH);
         v     = v & ((VALUE_WIDTH'(1) << nbits) - VALUE_WIDTH'(1));
         if (v == '0) v = VALUE_WIDTH'(1);
      end
      send_conversion(v, b);
   endtask

   // receiver: long hold-off when asked, otherwise random stalls
   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (rsp_idle_en) begin
            stall_left = pick_gap();
            rsp_tready = (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin : check_digits
      digit_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_digits.size() == 0) begin
            $error("unexpected result word: digit_char %h status %0d last %0d",
                   rsp_tdata[CHAR_WIDTH-1:0], rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = expected_digits.pop_front();
            if (rsp_tdata[CHAR_WIDTH-1:0] !== want.digit_char) begin
               $error("digit_char: expected %h, actual %h",
                      want.digit_char, rsp_tdata[CHAR_WIDTH-1:0]);
               mismatch_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // bad bases at both ends, base check ahead of value check, non-positive values
   task automatic test_status_codes();
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      send_conversion(VALUE_WIDTH'(100), BASE_WIDTH'(0));
      send_conversion(VALUE_WIDTH'(100), BASE_WIDTH'(1));
      send_conversion(VALUE_WIDTH'(100), BASE_WIDTH'(17));
      send_conversion(32'h7FFF_FFFF, BASE_WIDTH'(31));
      send_conversion('0, BASE_WIDTH'(0));
      send_conversion(32'h8000_0000, BASE_WIDTH'(31));
      send_conversion('0, BASE_WIDTH'(10));
      send_conversion(32'hFFFF_FFFF, BASE_WIDTH'(10));
      send_conversion(32'h8000_0000, BASE_WIDTH'(16));
      wait_drained();
   endtask

   // single digits, longest strings, every digit character
   task automatic test_digit_extremes();
      send_conversion(VALUE_WIDTH'(1), BASE_WIDTH'(2));
      send_conversion(32'h7FFF_FFFF, BASE_WIDTH'(2));
      send_conversion(32'h7FFF_FFFF, BASE_WIDTH'(16));
      send_conversion(32'h7FFF_FFFF, BASE_WIDTH'(3));
      send_conversion(32'h7EDC_BA98, BASE_WIDTH'(16));
      send_conversion(32'h0123_4567, BASE_WIDTH'(16));
      send_conversion(VALUE_WIDTH'(1234567890), BASE_WIDTH'(10));
      send_conversion(VALUE_WIDTH'(15), BASE_WIDTH'(16));
      send_conversion(VALUE_WIDTH'(16), BASE_WIDTH'(16));
      send_conversion(VALUE_WIDTH'(10), BASE_WIDTH'(11));
      send_conversion(VALUE_WIDTH'(5), BASE_WIDTH'(5));
      send_conversion(VALUE_WIDTH'(35), BASE_WIDTH'(7));
      wait_drained();
   endtask

   // random traffic, with a full drain pause halfway
   task automatic test_random_mix();
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      repeat (30) send_random_item();
      wait_drained();
      repeat (33) send_random_item();
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_receiver_holdoff();
      hold_left = HOLD_CYCLES;
      send_conversion(32'h7FFF_FFFF, BASE_WIDTH'(2));
      repeat (7) send_random_item();
      wait_drained();
   endtask

   // back-to-back words with no idling on either side
   task automatic test_no_idle();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      repeat (18) send_random_item();
      wait_drained();
   endtask

   // test sequence
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_status_codes();
      test_digit_extremes();
      test_random_mix();
      test_receiver_holdoff();
      test_no_idle();

      // catch any stray result words
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_digits.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
